@@ hdl/rrf_pkg.sv @@
// Shared types and defaults for the renaming register file.
// Holds the request and response payload structs and the command codes.
// No dependencies.
package rrf_pkg;

	// Default configuration of the block.
	localparam int NREGS_DEF        = 32;
	localparam int COMMIT_PORTS_DEF = 4;
	localparam int BCAST_PORTS_DEF  = 3;
	localparam int TAG_BITS_DEF     = 6;
	localparam int DATA_BITS_DEF    = 32;

	// Request command codes.
	typedef enum logic [2:0] {
		CMD_READ   = 3'd0,
		CMD_BCAST  = 3'd1,
		CMD_COMMIT = 3'd2,
		CMD_RENAME = 3'd3,
		CMD_STEP   = 3'd4,
		CMD_CLEAR  = 3'd5
	} rrf_cmd_t;

	// One request item.
	typedef struct packed {
		logic [2:0]         command;
		logic [1:0]         lane;
		logic               enable;
		logic [4:0]         reg_a;
		logic [4:0]         reg_b;
		logic [5:0]         tag;
		logic signed [31:0] value;
		logic signed [31:0] rob_value_a;
		logic signed [31:0] rob_value_b;
		logic               flush;
		logic               stall_req;
	} rrf_req_t;

	// One response item, produced for a read request.
	typedef struct packed {
		logic signed [31:0] value_a;
		logic               ready_a;
		logic [5:0]         tag_a;
		logic signed [31:0] value_b;
		logic               ready_b;
		logic [5:0]         tag_b;
	} rrf_rsp_t;

endpackage

@@ hdl/rrf_if.sv @@
// Valid/ready channel interfaces for the renaming register file.
// Depends on rrf_pkg for the payload structs.
interface rrf_req_if;
	logic               valid;
	logic               ready;
	rrf_pkg::rrf_req_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrf_rsp_if;
	logic               valid;
	logic               ready;
	rrf_pkg::rrf_rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/renaming_register_file_unit.sv @@
// Top level of the renaming register file with reorder-buffer tags.
// Depends on rrf_pkg and the channel interfaces in rrf_if.sv.
//
// Usage:
// Requests arrive on the req channel; responses leave on the rsp channel.
// Both are valid/ready channels and a request moves when valid and ready
// are high at a rising edge of clk. A read request gives one response with
// both operands; staging, step and clear requests give no response.
// A request is taken into an input register; from there the block either
// updates its state or forms the read response into the output register.
// A read response therefore passes through the input register and then
// the output register. One request is accepted every cycle while req.ready
// is high, set by the single input register feeding the output register.
// When the receiver stalls, the response holds in the output register and
// the input register keeps taking requests until a second read waits
// behind it; then req.ready drops until the response is taken.
// Reset (arst_n low) empties both registers, marks every register ready
// with value and tag zero, clears the pending flush and the staged lanes.
module renaming_register_file_unit #(
	parameter int NREGS        = rrf_pkg::NREGS_DEF,
	parameter int COMMIT_PORTS = rrf_pkg::COMMIT_PORTS_DEF,
	parameter int BCAST_PORTS  = rrf_pkg::BCAST_PORTS_DEF,
	parameter int TAG_BITS     = rrf_pkg::TAG_BITS_DEF,
	parameter int DATA_BITS    = rrf_pkg::DATA_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rrf_req_if.sink    req,
	rrf_rsp_if.source  rsp
);
	import rrf_pkg::*;

	localparam int RW = $clog2(NREGS);

	// Architectural and rename state.
	logic [DATA_BITS-1:0] regval_q [NREGS];
	logic [TAG_BITS-1:0]  tag_q [NREGS];
	logic [NREGS-1:0]     rdy_q;
	logic [NREGS-1:0]     inrob_q;
	logic                 flush_pend_q;

	logic [DATA_BITS-1:0] regval_d [NREGS];
	logic [TAG_BITS-1:0]  tag_d [NREGS];
	logic [NREGS-1:0]     rdy_d;
	logic [NREGS-1:0]     inrob_d;
	logic                 flush_d;

	// Staged broadcast, commit and rename lanes.
	logic [BCAST_PORTS-1:0]  bc_valid_q;
	logic [TAG_BITS-1:0]     bc_tag_q [BCAST_PORTS];
	logic [DATA_BITS-1:0]    bc_val_q [BCAST_PORTS];
	logic [COMMIT_PORTS-1:0] cm_en_q;
	logic [4:0]              cm_dest_q [COMMIT_PORTS];
	logic [DATA_BITS-1:0]    cm_val_q [COMMIT_PORTS];
	logic [TAG_BITS-1:0]     cm_tag_q [COMMIT_PORTS];
	logic [COMMIT_PORTS-1:0] rn_en_q;
	logic [4:0]              rn_dest_q [COMMIT_PORTS];
	logic [TAG_BITS-1:0]     rn_tag_q [COMMIT_PORTS];

	// Input and output registers.
	logic     valid_s1;
	rrf_req_t req_s1;
	logic     rsp_valid_q;
	rrf_rsp_t rsp_q;

	logic adv_s1;
	logic read_s1;

	logic [DATA_BITS-1:0] val_s1;
	logic [TAG_BITS-1:0]  tg_s1;

	logic [4:0]           rd_num [2];
	logic [DATA_BITS-1:0] rd_rob [2];
	logic [DATA_BITS-1:0] rd_val [2];
	logic                 rd_rdy [2];
	logic [TAG_BITS-1:0]  rd_tag [2];

	// The input register moves on unless a read waits on a full output.
	assign read_s1   = valid_s1 && (req_s1.command == CMD_READ);
	assign adv_s1    = valid_s1 && (!read_s1 || !rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Bring the request fields to the internal data and tag widths.
	assign val_s1    = DATA_BITS'($signed(req_s1.value));
	assign tg_s1     = TAG_BITS'(req_s1.tag);
	assign rd_num[0] = req_s1.reg_a;
	assign rd_num[1] = req_s1.reg_b;
	assign rd_rob[0] = DATA_BITS'($signed(req_s1.rob_value_a));
	assign rd_rob[1] = DATA_BITS'($signed(req_s1.rob_value_b));

	// Operand lookup: register value, then the first matching broadcast,
	// then the forwarded reorder-buffer value.
	always_comb begin
		for (int op = 0; op < 2; op++) begin
			rd_val[op] = '0;
			rd_rdy[op] = 1'b1;
			rd_tag[op] = '0;
			if (int'(rd_num[op]) < NREGS) begin
				rd_tag[op] = tag_q[RW'(rd_num[op])];
				if (rdy_q[RW'(rd_num[op])]) begin
					rd_val[op] = regval_q[RW'(rd_num[op])];
				end else begin
					rd_rdy[op] = 1'b0;
					for (int k = BCAST_PORTS - 1; k >= 0; k--) begin
						if (bc_valid_q[k] && bc_tag_q[k] == rd_tag[op]) begin
							rd_val[op] = bc_val_q[k];
							rd_rdy[op] = 1'b1;
						end
					end
					if (!rd_rdy[op] && inrob_q[RW'(rd_num[op])]) begin
						rd_val[op] = rd_rob[op];
						rd_rdy[op] = 1'b1;
					end
				end
			end
		end
	end

	// Next register state for step and clear requests.
	always_comb begin
		regval_d = regval_q;
		tag_d    = tag_q;
		rdy_d    = rdy_q;
		inrob_d  = inrob_q;
		flush_d  = flush_pend_q;
		if (adv_s1 && req_s1.command == CMD_CLEAR) begin
			for (int i = 0; i < NREGS; i++) begin
				regval_d[i] = '0;
				tag_d[i]    = '0;
			end
			rdy_d   = '1;
			inrob_d = '0;
			flush_d = 1'b0;
		end else if (adv_s1 && req_s1.command == CMD_STEP) begin
			if (flush_pend_q) begin
				for (int i = 0; i < NREGS; i++) begin
					tag_d[i] = '0;
				end
				rdy_d   = '1;
				inrob_d = '0;
				flush_d = 1'b0;
			end else begin
				flush_d = req_s1.flush;
				for (int i = 1; i < NREGS; i++) begin
					// Commit lanes in order; a matching tag retires the rename.
					for (int j = 0; j < COMMIT_PORTS; j++) begin
						if (cm_en_q[j] && int'(cm_dest_q[j]) == i) begin
							regval_d[i] = cm_val_q[j];
							if (tag_d[i] == cm_tag_q[j]) begin
								tag_d[i]   = '0;
								rdy_d[i]   = 1'b1;
								inrob_d[i] = 1'b0;
							end
						end
					end
					// Snoop the broadcasts for a waiting register.
					if (!rdy_d[i] && !inrob_d[i]) begin
						for (int k = 0; k < BCAST_PORTS; k++) begin
							if (bc_valid_q[k] && bc_tag_q[k] == tag_d[i]) begin
								inrob_d[i] = 1'b1;
							end
						end
					end
					// Rename lanes in order, unless stalled.
					if (!req_s1.stall_req) begin
						for (int j = 0; j < COMMIT_PORTS; j++) begin
							if (rn_en_q[j] && int'(rn_dest_q[j]) == i) begin
								tag_d[i]   = rn_tag_q[j];
								rdy_d[i]   = 1'b0;
								inrob_d[i] = 1'b0;
							end
						end
					end
				end
			end
		end
	end

	// Register file and staged lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				regval_q[i] <= '0;
				tag_q[i]    <= '0;
			end
			rdy_q        <= '1;
			inrob_q      <= '0;
			flush_pend_q <= 1'b0;
			bc_valid_q   <= '0;
			for (int k = 0; k < BCAST_PORTS; k++) begin
				bc_tag_q[k] <= '0;
				bc_val_q[k] <= '0;
			end
			cm_en_q <= '0;
			rn_en_q <= '0;
			for (int j = 0; j < COMMIT_PORTS; j++) begin
				cm_dest_q[j] <= '0;
				cm_val_q[j]  <= '0;
				cm_tag_q[j]  <= '0;
				rn_dest_q[j] <= '0;
				rn_tag_q[j]  <= '0;
			end
		end else begin
			regval_q     <= regval_d;
			tag_q        <= tag_d;
			rdy_q        <= rdy_d;
			inrob_q      <= inrob_d;
			flush_pend_q <= flush_d;
			if (adv_s1) begin
				case (req_s1.command)
					CMD_BCAST: begin
						for (int k = 0; k < BCAST_PORTS; k++) begin
							if (int'(req_s1.lane) == k) begin
								bc_valid_q[k] <= req_s1.enable;
								bc_tag_q[k]   <= tg_s1;
								bc_val_q[k]   <= val_s1;
							end
						end
					end
					CMD_COMMIT: begin
						for (int j = 0; j < COMMIT_PORTS; j++) begin
							if (int'(req_s1.lane) == j) begin
								cm_en_q[j]   <= req_s1.enable;
								cm_dest_q[j] <= req_s1.reg_a;
								cm_val_q[j]  <= val_s1;
								cm_tag_q[j]  <= tg_s1;
							end
						end
					end
					CMD_RENAME: begin
						for (int j = 0; j < COMMIT_PORTS; j++) begin
							if (int'(req_s1.lane) == j) begin
								rn_en_q[j]   <= req_s1.enable;
								rn_dest_q[j] <= req_s1.reg_a;
								rn_tag_q[j]  <= tg_s1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1 && read_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && read_s1) begin
			rsp_q.value_a <= 32'(rd_val[0]);
			rsp_q.ready_a <= rd_rdy[0];
			rsp_q.tag_a   <= 6'(rd_tag[0]);
			rsp_q.value_b <= 32'(rd_val[1]);
			rsp_q.ready_b <= rd_rdy[1];
			rsp_q.tag_b   <= 6'(rd_tag[1]);
		end
	end

endmodule

@@ hdl/rrf_checker.sv @@
// Port-level checker for the renaming register file, bound to the top level.
// Depends on rrf_pkg and renaming_register_file_unit.
module rrf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rrf_pkg::rrf_rsp_t rsp_data
);
	import rrf_pkg::*;

	// A stalled response stays valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("response payload changed while stalled");

	// With the output register empty, a new request is always taken.
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty output register");

	// An operand that is not available reads as zero.
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.ready_a || rsp_data.value_a == 0) &&
			(rsp_data.ready_b || rsp_data.value_b == 0))
		else $error("unavailable operand with nonzero value");

endmodule

bind renaming_register_file_unit rrf_checker u_rrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

@@ sim/tb.sv @@
// Self-checking testbench for renaming_register_file_unit: a directed table, then random
// requests, each checked against an in-bench model of the rename table with random stalls.
// Depends on rrf_pkg and the channel interfaces in rrf_if.sv.
module tb;
	import rrf_pkg::*;

	localparam int NREG        = NREGS_DEF;
	localparam int NCOMMIT     = COMMIT_PORTS_DEF;
	localparam int NBCAST      = BCAST_PORTS_DEF;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 23;
	localparam int PRINT_CAP    = 40;

	typedef struct {
		rrf_req_t r;
		bit       known;
		rrf_rsp_t answer;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrf_req_if req();
	rrf_rsp_if rsp();

	renaming_register_file_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Shadow copy of the register status table and the staged lanes.
	logic [31:0] file_value [NREG];
	logic [5:0]  file_tag [NREG];
	logic        file_ready [NREG];
	logic        file_in_rob [NREG];
	logic        flush_armed;
	logic        bc_valid [NBCAST];
	logic [5:0]  bc_tag [NBCAST];
	logic [31:0] bc_value [NBCAST];
	logic        cm_en [NCOMMIT];
	logic [4:0]  cm_dest [NCOMMIT];
	logic [31:0] cm_value [NCOMMIT];
	logic [5:0]  cm_tag [NCOMMIT];
	logic        rn_en [NCOMMIT];
	logic [4:0]  rn_dest [NCOMMIT];
	logic [5:0]  rn_tag [NCOMMIT];

	rrf_rsp_t  operands_due [$];
	plan_row_t plan [$];
	rrf_rsp_t  got_ops;
	rrf_rsp_t  want_ops;
	int        mismatches = 0;
	int        cycle_count = 0;
	int        hold_left = 0;
	bit        hold_req = 1'b0;
	bit        hold_taken = 1'b0;
	bit        quiet = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Register status goes back to ready with tag zero, values to zero unless kept, flush disarmed; lanes are untouched.
	function automatic void reset_regs(bit keep_values);
		for (int i = 0; i < NREG; i++) begin
			if (!keep_values)
				file_value[i] = '0;
			file_tag[i] = '0;
			file_ready[i] = 1'b1;
			file_in_rob[i] = 1'b0;
		end
		flush_armed = 1'b0;
	endfunction

	// One operand: register value, else first matching broadcast, else the ROB value.
	function automatic void operand_lookup(input logic [4:0] r, input logic [31:0] rob,
			output logic [31:0] v, output logic rd, output logic [5:0] t);
		v = '0;
		rd = 1'b1;
		t = file_tag[r];
		if (file_ready[r]) begin
			v = file_value[r];
		end else begin
			rd = 1'b0;
			for (int k = 0; k < NBCAST; k++) begin
				if (!rd && bc_valid[k] && bc_tag[k] == t) begin
					v = bc_value[k];
					rd = 1'b1;
				end
			end
			if (!rd && file_in_rob[r]) begin
				v = rob;
				rd = 1'b1;
			end
		end
	endfunction

	// A step: pending flush, or commits, then broadcast snooping, then renames.
	function automatic void step_file(logic fl, logic stall);
		logic [4:0] d;
		if (flush_armed) begin
			reset_regs(1'b1);
			return;
		end
		flush_armed = fl;
		for (int j = 0; j < NCOMMIT; j++) begin
			d = cm_dest[j];
			if (cm_en[j] && d != 0) begin
				file_value[d] = cm_value[j];
				if (file_tag[d] == cm_tag[j]) begin
					file_tag[d] = '0;
					file_ready[d] = 1'b1;
					file_in_rob[d] = 1'b0;
				end
			end
		end
		for (int i = 1; i < NREG; i++) begin
			if (!file_ready[i] && !file_in_rob[i]) begin
				for (int k = 0; k < NBCAST; k++) begin
					if (bc_valid[k] && bc_tag[k] == file_tag[i])
						file_in_rob[i] = 1'b1;
				end
			end
		end
		if (!stall) begin
			for (int j = 0; j < NCOMMIT; j++) begin
				d = rn_dest[j];
				if (rn_en[j] && d != 0) begin
					file_tag[d] = rn_tag[j];
					file_ready[d] = 1'b0;
					file_in_rob[d] = 1'b0;
				end
			end
		end
	endfunction

	// Applies one accepted request; a read queues the operands it should return.
	function automatic void apply_request(rrf_req_t r, bit known, rrf_rsp_t answer);
		rrf_rsp_t o;
		o = '0;
		case (r.command)
			CMD_READ: begin
				operand_lookup(r.reg_a, r.rob_value_a, o.value_a, o.ready_a, o.tag_a);
				operand_lookup(r.reg_b, r.rob_value_b, o.value_b, o.ready_b, o.tag_b);
				operands_due.push_back(known ? answer : o);
			end
			CMD_BCAST: begin
				if (r.lane < NBCAST) begin
					bc_valid[r.lane] = r.enable;
					bc_tag[r.lane] = r.tag;
					bc_value[r.lane] = r.value;
				end
			end
			CMD_COMMIT: begin
				if (r.lane < NCOMMIT) begin
					cm_en[r.lane] = r.enable;
					cm_dest[r.lane] = r.reg_a;
					cm_value[r.lane] = r.value;
					cm_tag[r.lane] = r.tag;
				end
			end
			CMD_RENAME: begin
				if (r.lane < NCOMMIT) begin
					rn_en[r.lane] = r.enable;
					rn_dest[r.lane] = r.reg_a;
					rn_tag[r.lane] = r.tag;
				end
			end
			CMD_STEP: step_file(r.flush, r.stall_req);
			CMD_CLEAR: reset_regs(1'b0);
			default: ;
		endcase
	endfunction

	function automatic rrf_req_t mk(logic [2:0] cmd, logic [1:0] lane, logic en,
			logic [4:0] a, logic [4:0] b, logic [5:0] tag, logic [31:0] val,
			logic [31:0] va, logic [31:0] vb, logic fl, logic st);
		rrf_req_t r;
		r.command = cmd;
		r.lane = lane;
		r.enable = en;
		r.reg_a = a;
		r.reg_b = b;
		r.tag = tag;
		r.value = val;
		r.rob_value_a = va;
		r.rob_value_b = vb;
		r.flush = fl;
		r.stall_req = st;
		return r;
	endfunction

	function automatic rrf_rsp_t ans(logic [31:0] va, logic ra, logic [5:0] ta,
			logic [31:0] vb, logic rb, logic [5:0] tb_tag);
		rrf_rsp_t o;
		o.value_a = va;
		o.ready_a = ra;
		o.tag_a = ta;
		o.value_b = vb;
		o.ready_b = rb;
		o.tag_b = tb_tag;
		return o;
	endfunction

	// Random request, mostly on a few hot registers and tags so renames,
	// broadcasts and commits meet each other.
	function automatic rrf_req_t draw_request();
		rrf_req_t r;
		int pick;
		logic [4:0] d;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(rrf_req_t)-1:0];
		pick = $urandom_range(99);
		if ($urandom_range(3) != 0)
			r.reg_a = 5'($urandom_range(1, 6));
		if ($urandom_range(3) != 0)
			r.reg_b = 5'($urandom_range(0, 6));
		if ($urandom_range(3) != 0)
			r.tag = 6'($urandom_range(0, 7));
		if (pick < 30) begin
			r.command = CMD_READ;
		end else if (pick < 44) begin
			r.command = CMD_BCAST;
			r.enable = ($urandom_range(3) != 0);
			d = 5'($urandom_range(1, 6));
			if ($urandom_range(1) != 0)
				r.tag = file_tag[d];
		end else if (pick < 58) begin
			r.command = CMD_COMMIT;
			if ($urandom_range(1) != 0)
				r.tag = file_tag[r.reg_a];
		end else if (pick < 72) begin
			r.command = CMD_RENAME;
		end else if (pick < 95) begin
			r.command = CMD_STEP;
			r.flush = ($urandom_range(24) == 0);
			r.stall_req = ($urandom_range(4) == 0);
		end else if (pick < 98) begin
			r.command = CMD_CLEAR;
		end else begin
			r.command = ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
		end
		return r;
	endfunction

	// Offers one request, with a random gap first, and waits until it is taken.
	task automatic push_req(rrf_req_t r, bit known, rrf_rsp_t answer);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do
			@(posedge clk);
		while (!req.ready);
		apply_request(r, known, answer);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
	endtask

	// Response side: random stalls, a long hold-off on request, none while quiet.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Each response is compared field by field with the oldest outstanding read.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			got_ops = rsp.data;
			if (operands_due.size() == 0) begin
				report_mismatch("response with no read outstanding", got_ops.value_a, '0);
			end else begin
				want_ops = operands_due.pop_front();
				if (got_ops.value_a !== want_ops.value_a)
					report_mismatch("value_a", got_ops.value_a, want_ops.value_a);
				if (got_ops.ready_a !== want_ops.ready_a)
					report_mismatch("ready_a", got_ops.ready_a, want_ops.ready_a);
				if (got_ops.tag_a !== want_ops.tag_a)
					report_mismatch("tag_a", got_ops.tag_a, want_ops.tag_a);
				if (got_ops.value_b !== want_ops.value_b)
					report_mismatch("value_b", got_ops.value_b, want_ops.value_b);
				if (got_ops.ready_b !== want_ops.ready_b)
					report_mismatch("ready_b", got_ops.ready_b, want_ops.ready_b);
				if (got_ops.tag_b !== want_ops.tag_b)
					report_mismatch("tag_b", got_ops.tag_b, want_ops.tag_b);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		reset_regs(1'b0);
		for (int k = 0; k < NBCAST; k++) begin
			bc_valid[k] = 1'b0;
			bc_tag[k] = '0;
			bc_value[k] = '0;
		end
		for (int j = 0; j < NCOMMIT; j++) begin
			cm_en[j] = 1'b0;
			cm_dest[j] = '0;
			cm_value[j] = '0;
			cm_tag[j] = '0;
			rn_en[j] = 1'b0;
			rn_dest[j] = '0;
			rn_tag[j] = '0;
		end

		// Directed table: reset state, value extremes, register zero, stalled and
		// applied renames, broadcast forwarding, ROB forwarding, flush, clear.
		plan.push_back('{mk(CMD_READ, 0, 0, 0, 31, 0, 0, '1, '1, 0, 0), 1'b1,
			ans(0, 1, 0, 0, 1, 0)});
		plan.push_back('{mk(CMD_COMMIT, 0, 1, 31, 0, 0, 32'h7fffffff, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_COMMIT, 3, 1, 1, 0, 0, 32'h80000000, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_COMMIT, 1, 1, 0, 0, 0, 32'hffffffff, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 31, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			ans(32'h7fffffff, 1, 0, 32'h80000000, 1, 0)});
		plan.push_back('{mk(CMD_RENAME, 0, 1, 5, 0, 63, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_RENAME, 3, 1, 0, 0, 7, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			ans(0, 1, 0, 0, 1, 0)});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_RENAME, 0, 0, 5, 0, 63, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 5, 5, 0, 0, 32'h12345678, 32'h12345678, 0, 0),
			1'b1, ans(0, 0, 63, 0, 0, 63)});
		plan.push_back('{mk(CMD_BCAST, 2, 1, 0, 0, 63, 32'hdeadbeef, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_BCAST, 3, 1, 0, 0, 63, 1, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 5, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_BCAST, 2, 0, 0, 0, 63, 32'hdeadbeef, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 5, 5, 0, 0, 32'h12345678, 32'h80000000, 0, 0),
			1'b0, '0});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 5, 31, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_SPARE_7, '1, 1, '1, '1, '1, '1, '1, '1, 1, 1), 1'b0, '0});
		plan.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(CMD_READ, 0, 0, 31, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			ans(0, 1, 0, 0, 1, 0)});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			push_req(plan[i].r, plan[i].known, plan[i].answer);

		// Random requests: a quiet stretch with no idling, then a long response hold-off.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 400 && n < 650);
			if (n == 800)
				hold_req = 1'b1;
			push_req(draw_request(), 1'b0, '0);
		end
		req.valid <= 1'b0;

		while (operands_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/rrf_pkg.sv
hdl/rrf_if.sv
hdl/renaming_register_file_unit.sv
hdl/rrf_checker.sv
sim/tb.sv
